// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; compiled to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- rtl/feal_pkg.sv -----
// Types, register indexes and the round function of the FEAL-4 encryption pipeline.
package feal_pkg;

   localparam int HalfWidth  = 32;
   localparam int BlockWidth = 2 * HalfWidth;
   localparam int IndexWidth = 3;

   typedef logic [HalfWidth-1:0] half_type;

   typedef enum logic [IndexWidth-1:0] {
      IDX_KEY_LEFT    = 3'd0,
      IDX_KEY_RIGHT   = 3'd1,
      IDX_ROUND_KEY_1 = 3'd2,
      IDX_ROUND_KEY_2 = 3'd3,
      IDX_ROUND_KEY_3 = 3'd4,
      IDX_ROUND_KEY_4 = 3'd5
   } csr_index_type;

   typedef struct packed {
      half_type key_left;
      half_type key_right;
      half_type round_key_1;
      half_type round_key_2;
      half_type round_key_3;
      half_type round_key_4;
   } key_set_type;

   // G(a,b,d): byte sum, then rotate left by two
   function automatic logic [7:0] mix_g(input logic [7:0] a, input logic [7:0] b,
                                        input logic d);
      logic [7:0] s;
      s = a + b + {7'd0, d};
      return {s[5:0], s[7:6]};
   endfunction

   // bytes taken little-endian: x0 is bits 7:0
   function automatic half_type round_fn(input half_type w);
      logic [7:0] y0, y1, y2, y3;
      y1 = mix_g(w[7:0] ^ w[15:8], w[23:16] ^ w[31:24], 1'b1);
      y0 = mix_g(w[7:0], y1, 1'b0);
      y2 = mix_g(w[23:16] ^ w[31:24], y1, 1'b0);
      y3 = mix_g(w[31:24], y2, 1'b1);
      return {y3, y2, y1, y0};
   endfunction

endpackage

// ----- rtl/feal_csr.sv -----
// Key register file written through the configuration channel.
module feal_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [feal_pkg::IndexWidth-1:0]   csr_index,
   input  logic [feal_pkg::HalfWidth-1:0]    csr_wdata,
   output feal_pkg::key_set_type             keys
);
   import feal_pkg::*;

   key_set_type keys_ff, keys_in;

   assign csr_ready = 1'b1;
   assign keys      = keys_ff;

   always_comb begin
      keys_in = keys_ff;
      if (csr_valid) begin
         unique case (csr_index)
            IDX_KEY_LEFT:    keys_in.key_left    = csr_wdata;
            IDX_KEY_RIGHT:   keys_in.key_right   = csr_wdata;
            IDX_ROUND_KEY_1: keys_in.round_key_1 = csr_wdata;
            IDX_ROUND_KEY_2: keys_in.round_key_2 = csr_wdata;
            IDX_ROUND_KEY_3: keys_in.round_key_3 = csr_wdata;
            IDX_ROUND_KEY_4: keys_in.round_key_4 = csr_wdata;
            default:         keys_in = keys_ff;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

endmodule

// ----- rtl/feal_round.sv -----
// One swapping Feistel round as a registered pipeline stage.
module feal_round (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [feal_pkg::HalfWidth-1:0]  in_l,
   input  logic [feal_pkg::HalfWidth-1:0]  in_r,
   input  logic [feal_pkg::HalfWidth-1:0]  round_key,
   output logic                            out_valid,
   output logic [feal_pkg::HalfWidth-1:0]  out_l,
   output logic [feal_pkg::HalfWidth-1:0]  out_r
);
   import feal_pkg::*;

   logic     valid_ff;
   half_type l_ff, l_in;
   half_type r_ff, r_in;

   always_comb begin
      l_in = in_r;
      r_in = in_l ^ round_fn(in_r ^ round_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      r_ff <= r_in;
   end

   assign out_valid = valid_ff;
   assign out_l     = l_ff;
   assign out_r     = r_ff;

endmodule

// ----- rtl/feal_final.sv -----
// Last round without swap plus the closing half mix, registered onto the result ports.
module feal_final (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [feal_pkg::HalfWidth-1:0]   in_l,
   input  logic [feal_pkg::HalfWidth-1:0]   in_r,
   input  logic [feal_pkg::HalfWidth-1:0]   round_key,
   output logic                             out_valid,
   output logic [feal_pkg::BlockWidth-1:0]  out_block
);
   import feal_pkg::*;

   logic     valid_ff;
   half_type l_in, r_in;
   logic [BlockWidth-1:0] block_ff;

   always_comb begin
      l_in = in_l ^ round_fn(in_r ^ round_key);
      r_in = in_r ^ l_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= {l_in, r_in};
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

// ----- rtl/feal4_block_encrypt_top.sv -----
// FEAL-4 block encryption engine, five-stage pipeline, top level.
//
//   channel   direction  handshake              payload
//   request   in         start & !busy          req_plaintext[63:0]
//   response  out        rsp_valid (strobe)     rsp_ciphertext[63:0]
//   csr       in         csr_valid & csr_ready  csr_index[2:0], csr_wdata[31:0]
//
// One block accepted per cycle while busy is low; each block passes through the
// whitening stage, three swapping rounds and the final round, one pipeline
// register per round function.
// Synchronous reset clears all stage valid bits and zeroes the keys; busy
// is high only while reset is asserted.
// No back-pressure: the response strobe lasts one cycle and must be taken.
module feal4_block_encrypt_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [feal_pkg::BlockWidth-1:0]   req_plaintext,
   output logic                              rsp_valid,
   output logic [feal_pkg::BlockWidth-1:0]   rsp_ciphertext,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [feal_pkg::IndexWidth-1:0]   csr_index,
   input  logic [feal_pkg::HalfWidth-1:0]    csr_wdata
);
   import feal_pkg::*;

`include "assert_macros.svh"

   key_set_type keys;
   logic        accept;

   logic     wh_valid_ff;
   half_type wh_l_ff, wh_l_in;
   half_type wh_r_ff, wh_r_in;

   logic     s1_valid, s2_valid, s3_valid;
   half_type s1_l, s1_r, s2_l, s2_r, s3_l, s3_r;

   assign busy   = reset;
   assign accept = start & ~busy;

   feal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .keys      (keys)
   );

   // whitening and the first right ^= left
   always_comb begin
      wh_l_in = req_plaintext[BlockWidth-1:HalfWidth] ^ keys.key_left;
      wh_r_in = req_plaintext[HalfWidth-1:0] ^ keys.key_right ^ wh_l_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_valid_ff <= 1'b0;
      end else begin
         wh_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      wh_l_ff <= wh_l_in;
      wh_r_ff <= wh_r_in;
   end

   feal_round u_round1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wh_valid_ff),
      .in_l      (wh_l_ff),
      .in_r      (wh_r_ff),
      .round_key (keys.round_key_1),
      .out_valid (s1_valid),
      .out_l     (s1_l),
      .out_r     (s1_r)
   );

   feal_round u_round2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_l      (s1_l),
      .in_r      (s1_r),
      .round_key (keys.round_key_2),
      .out_valid (s2_valid),
      .out_l     (s2_l),
      .out_r     (s2_r)
   );

   feal_round u_round3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_l      (s2_l),
      .in_r      (s2_r),
      .round_key (keys.round_key_3),
      .out_valid (s3_valid),
      .out_l     (s3_l),
      .out_r     (s3_r)
   );

   feal_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_l      (s3_l),
      .in_r      (s3_r),
      .round_key (keys.round_key_4),
      .out_valid (rsp_valid),
      .out_block (rsp_ciphertext)
   );

   // every accepted transaction comes out as a response, and nothing else does
   `ASSERT_PROP(a_accept_gives_rsp, clock, reset, accept |-> ##5 rsp_valid)
   `ASSERT_PROP(a_rsp_has_source, clock, reset, rsp_valid |-> $past(accept, 5))
   `ASSERT_PROP(a_mid_valid_tracks, clock, reset, s3_valid == $past(wh_valid_ff, 3))
   `ASSERT_NEVER(a_busy_out_of_reset, clock, reset, busy)

endmodule
